[src/tlgm_pkg.sv]
// Shared constants and command/status types for the tremolo gain modulator.
package tlgm_pkg;

  // LFO values are Q1.15 in [-1.0, +1.0], so they need 17 signed bits
  localparam int LFO_W   = 17;
  localparam int PHASE_W = 32;
  // depth*mix product, each clamped to 2^15
  localparam int DM_W    = 31;
  // modulation factor m, Q30 in [-2^30, 2^30]
  localparam int MOD_W   = 32;

  localparam logic [15:0] Q15_ONE = 16'd32768;
  localparam logic signed [LFO_W-1:0] LFO_POS_ONE = 17'sd32768;
  localparam logic signed [LFO_W-1:0] LFO_NEG_ONE = -17'sd32768;
  localparam logic signed [LFO_W-1:0] LFO_ZERO    = 17'sd0;

  // pi/2 in Q30, used when the sine table is built
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // configuration register indexes
  localparam logic [1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [1:0] CFG_DEPTH      = 2'd1;
  localparam logic [1:0] CFG_MIX        = 2'd2;
  localparam logic [1:0] CFG_WAVE       = 2'd3;

  // LFO shape codes
  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [1:0] WAVE_SQUARE   = 2'd2;

  localparam int CFG_DATA_W  = 24;
  localparam int PHASE_STEP_W = 24;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture the input word
    logic lfo_en;    // register LFO value and depth*mix
    logic mul1_en;   // m = round(lfo*depth*mix / 2^15)
    logic mul2_en;   // product = x*m
    logic out_en;    // round, add, saturate, advance phase
  } tlgm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a word this cycle
  } tlgm_status_t;

endpackage

[src/tlgm_sine_rom.sv]
// Sine lookup table built at elaboration, addressed by LFO phase, registered read.
module tlgm_sine_rom #(
  parameter int ENTRIES = 1024
) (
  input  logic                           clk,
  input  logic [tlgm_pkg::PHASE_W-1:0]   phase,
  output logic signed [tlgm_pkg::LFO_W-1:0] data
);
  import tlgm_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int SCL_W = PHASE_W + IDX_W + 1;

  typedef logic signed [LFO_W-1:0] rom_t [ENTRIES];

  // quadrant fold, Q30 Taylor series to x^11, round half up to Q15
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    logic [1:0]  quad;
    int          k;
    for (k = 0; k < ENTRIES; k++) begin
      f    = (64'(k) << 32) / 64'(ENTRIES);
      quad = f[31:30];
      r    = {34'd0, f[29:0]};
      if (quad[0]) r = (64'd1 << 30) - r;
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = (64'd1 << 30) - x2 / 64'd110;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s + 64'd16384) >> 15;
      if (v > 64'd32768) v = 64'd32768;
      rom[k] = quad[1] ? -LFO_W'(v) : LFO_W'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_TABLE = build_rom();

  logic [SCL_W-1:0] scaled;
  logic [IDX_W-1:0] idx;

  // index = phase*N / 2^32, always below N
  assign scaled = SCL_W'(phase) * SCL_W'(ENTRIES);
  assign idx    = scaled[PHASE_W +: IDX_W];

  // read the table every cycle
  always_ff @(posedge clk) begin
    data <= SINE_TABLE[idx];
  end

endmodule

[src/tlgm_datapath.sv]
// Datapath: config registers, LFO phase, arithmetic steps and output register.
module tlgm_datapath #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int SAMPLE_BITS        = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_index,
  input  logic [tlgm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in,
  input  tlgm_pkg::tlgm_cmd_t             cmd,
  output tlgm_pkg::tlgm_status_t          status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]   sample_out
);
  import tlgm_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + MOD_W;
  localparam int Y_W    = SAMPLE_BITS + 2;
  localparam int P1_W   = LFO_W + DM_W + 1;
  localparam longint Y_MAX_L = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [Y_W-1:0]    Y_MAX  = Y_W'(Y_MAX_L);
  localparam logic signed [Y_W-1:0]    Y_MIN  = Y_W'(-Y_MAX_L - 1);
  localparam logic signed [PROD_W-1:0] RND30  = PROD_W'(longint'(1) << 29);
  localparam logic signed [P1_W-1:0]   RND15  = P1_W'(16384);

  // configuration
  logic [PHASE_STEP_W-1:0] phase_step;
  logic [15:0]             depth_amount;
  logic [15:0]             mix_amount;
  logic [1:0]              wave_select;

  // working registers
  logic [PHASE_W-1:0]          phase;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [LFO_W-1:0]     lfo_q;
  logic [DM_W-1:0]             dm_q;
  logic signed [MOD_W-1:0]     m_q;
  logic signed [PROD_W-1:0]    prod_q;

  logic signed [LFO_W-1:0]  rom_data;
  logic signed [LFO_W-1:0]  lfo_val;
  logic signed [18:0]       tri_w;
  logic [16:0]              p15;
  logic [15:0]              depth_c;
  logic [15:0]              mix_c;
  logic signed [P1_W-1:0]   p1;
  logic signed [PROD_W-1:0] delta;
  logic signed [Y_W-1:0]    y_w;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  tlgm_sine_rom #(
    .ENTRIES (SINE_TABLE_ENTRIES)
  ) u_rom (
    .clk   (clk),
    .phase (phase),
    .data  (rom_data)
  );

  // hold config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= '0;
      depth_amount <= '0;
      mix_amount   <= '0;
      wave_select  <= WAVE_SINE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PHASE_STEP: phase_step   <= cfg_data[PHASE_STEP_W-1:0];
        CFG_DEPTH:      depth_amount <= cfg_data[15:0];
        CFG_MIX:        mix_amount   <= cfg_data[15:0];
        CFG_WAVE:       wave_select  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // triangle: rise, fall over the middle half, rise again
  assign p15 = phase[PHASE_W-1:15];
  always_comb begin
    case (phase[31:30])
      2'b00:          tri_w = 19'(p15);
      2'b01, 2'b10:   tri_w = 19'sd65536 - 19'(p15);
      default:        tri_w = 19'(p15) - 19'sd131072;
    endcase
  end

  // select the LFO shape
  always_comb begin
    case (wave_select)
      WAVE_SINE:     lfo_val = rom_data;
      WAVE_TRIANGLE: lfo_val = LFO_W'(tri_w);
      WAVE_SQUARE:   lfo_val = phase[31] ? LFO_NEG_ONE : LFO_POS_ONE;
      default:       lfo_val = LFO_ZERO;
    endcase
  end

  // clamp depth and mix to one
  assign depth_c = (depth_amount > Q15_ONE) ? Q15_ONE : depth_amount;
  assign mix_c   = (mix_amount > Q15_ONE) ? Q15_ONE : mix_amount;

  // first multiply with round half up
  assign p1 = P1_W'(lfo_q) * P1_W'(signed'({1'b0, dm_q}));

  // second rounding, add dry sample, saturate
  assign delta = (prod_q + RND30) >>> 30;
  assign y_w   = Y_W'(x_q) + Y_W'(delta);
  always_comb begin
    if (y_w > Y_MAX)      y_sat = SAMPLE_BITS'(Y_MAX);
    else if (y_w < Y_MIN) y_sat = SAMPLE_BITS'(Y_MIN);
    else                  y_sat = SAMPLE_BITS'(y_w);
  end

  // advance the arithmetic steps
  always_ff @(posedge clk) begin
    if (cmd.load_in) x_q <= sample_in;
    if (cmd.lfo_en) begin
      lfo_q <= lfo_val;
      dm_q  <= DM_W'(depth_c) * DM_W'(mix_c);
    end
    if (cmd.mul1_en) m_q <= MOD_W'((p1 + RND15) >>> 15);
    if (cmd.mul2_en) prod_q <= PROD_W'(x_q) * PROD_W'(m_q);
    if (cmd.out_en) sample_out <= y_sat;
  end

  // advance phase once per item; hold output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_en) begin
        phase     <= phase + PHASE_W'(phase_step);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

[src/tlgm_ctrl.sv]
// Controller: walks one word through LFO, two multiply steps and output.
module tlgm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tlgm_pkg::tlgm_status_t status,
  output tlgm_pkg::tlgm_cmd_t    cmd
);
  import tlgm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LFO,
    S_MUL1,
    S_MUL2,
    S_OUT
  } state_t;

  state_t state;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_LFO;
        S_LFO:  state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_OUT;
        S_OUT:  if (status.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // decode commands
  assign in_ready    = (state == S_IDLE);
  assign cmd.load_in = (state == S_IDLE) && in_valid;
  assign cmd.lfo_en  = (state == S_LFO);
  assign cmd.mul1_en = (state == S_MUL1);
  assign cmd.mul2_en = (state == S_MUL2);
  assign cmd.out_en  = (state == S_OUT) && status.out_free;

endmodule

[src/tremolo_lfo_gain_modulator.sv]
// Top level: tremolo LFO gain modulator with stream ports and config write port.
// The controller takes one word at a time through LFO lookup, the two multiply steps
// and the saturating add, and accepts the next input word only once back in idle.
// A waiting output word does not block the next input word from being accepted.
// Reset (synchronous) clears LFO phase and all config registers; no clearing pass.
module tremolo_lfo_gain_modulator #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int SAMPLE_BITS        = 24,
  localparam int TDATA_W           = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_index,
  input  logic [tlgm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TDATA_W-1:0]              s_axis_tdata,  // [SAMPLE_BITS-1:0] sample_in
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [TDATA_W-1:0]              m_axis_tdata   // [SAMPLE_BITS-1:0] sample_out
);
  import tlgm_pkg::*;

  tlgm_cmd_t    cmd;
  tlgm_status_t status;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  tlgm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tlgm_datapath #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .SAMPLE_BITS        (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (signed'(s_axis_tdata[SAMPLE_BITS-1:0])),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .sample_out (sample_out)
  );

  // pad the output word with zeros to whole bytes
  assign m_axis_tdata = TDATA_W'(unsigned'(sample_out));

endmodule
